[design/spdpi_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spdpi_pkg
// Shared constants for the speed PI controller with output filter.
// ----------------------------------------------------------------------------
package spdpi_pkg;

	// Default width of the speed fields.
	localparam int SPEED_WIDTH_DEF = 16;

	// Configuration register indexes.
	localparam logic [1:0] REG_PROP_GAIN    = 2'd0;
	localparam logic [1:0] REG_INTEG_GAIN   = 2'd1;
	localparam logic [1:0] REG_FILTER_ALPHA = 2'd2;
	localparam logic [1:0] REG_OUTPUT_LIMIT = 2'd3;

	// Register widths and reset values (gains Q8.8, alpha Q1.16).
	localparam int GAIN_W  = 16;
	localparam int ALPHA_W = 17;
	localparam int LIMIT_W = 15;
	localparam int CFG_W   = 17;

	localparam logic [GAIN_W-1:0]  PROP_GAIN_RST    = 16'd3648;
	localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST   = 16'd1024;
	localparam logic [ALPHA_W-1:0] FILTER_ALPHA_RST = 17'd62259;
	localparam logic [LIMIT_W-1:0] OUTPUT_LIMIT_RST = 15'd5000;

	// Unity in Q1.16.
	localparam logic [ALPHA_W-1:0] ONE_Q16 = 17'h1_0000;

	// Width of the stored filter value and of the drive output.
	localparam int FILT_W  = 48;
	localparam int DRIVE_W = 16;

endpackage
`default_nettype wire

[design/speed_pi_with_output_filter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// speed_pi_with_output_filter
// Incremental PI speed controller followed by a first-order output filter.
// ----------------------------------------------------------------------------
// A result is offered once an accepted input has passed through all states,
// later only if the previous result is still waiting downstream. No new input
// is taken until the result is offered; five products go through a single
// shared multiplier, each followed by an accumulate or finishing step.
// Reset (arst_n low, asynchronous): gains, alpha and limit return to their
// defaults, and the stored error, output and filter value clear to zero.
// ----------------------------------------------------------------------------
module speed_pi_with_output_filter #(
	parameter int SPEED_WIDTH = spdpi_pkg::SPEED_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,

	// Configuration write port.
	input  wire logic                          cfg_we,
	input  wire logic [1:0]                    cfg_index,
	input  wire logic [spdpi_pkg::CFG_W-1:0]   cfg_data,

	// Input stream.
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	// tdata fields, lowest bit first: target_speed, measured_speed, zero pad.
	input  wire logic [((2*SPEED_WIDTH+7)/8)*8-1:0] s_axis_tdata,

	// Output stream.
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// tdata fields, lowest bit first: drive_out.
	output logic [spdpi_pkg::DRIVE_W-1:0]      m_axis_tdata,
	// tuser fields, lowest bit first: saturated.
	output logic                               m_axis_tuser
);

	// ------------------------------------------------------------------
	// Derived widths. The error needs one bit more than a speed, the
	// error change two. The shared multiplier takes a signed operand wide
	// enough for the error change or a 32-bit value, times an 18-bit
	// signed operand that carries an unsigned gain or filter weight.
	// ------------------------------------------------------------------
	localparam int SW     = SPEED_WIDTH;
	localparam int ERR_W  = SW + 1;
	localparam int DERR_W = SW + 2;
	localparam int MA_W   = (DERR_W > 32) ? DERR_W : 32;
	localparam int MB_W   = 18;
	localparam int PR_W   = MA_W + MB_W;
	localparam int ACC_W  = PR_W + 2;
	localparam int INC_W  = ACC_W - 8;
	localparam int SUM_W  = INC_W + 1;
	localparam int O_W    = ACC_W - 16;
	localparam int FW     = spdpi_pkg::FILT_W;
	localparam int DW     = spdpi_pkg::DRIVE_W;

	// Signed 32-bit saturation bounds at the width of the pre-filter sum.
	localparam logic signed [SUM_W-1:0] SAT_HI = {{(SUM_W-32){1'b0}}, 32'h7FFF_FFFF};
	localparam logic signed [SUM_W-1:0] SAT_LO = {{(SUM_W-32){1'b1}}, 32'h8000_0000};

	// Sequencer states. Each multiply state loads the product register;
	// the state after it folds that product into the accumulator.
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MP   = 4'd1; // kp * error change
	localparam logic [3:0] ST_MI   = 4'd2; // ki * error
	localparam logic [3:0] ST_NUM  = 4'd3; // finish the PI numerator
	localparam logic [3:0] ST_SUM  = 4'd4; // increment, add, saturate
	localparam logic [3:0] ST_MS   = 4'd5; // sum * alpha
	localparam logic [3:0] ST_MH   = 4'd6; // high part of previous * weight
	localparam logic [3:0] ST_ML   = 4'd7; // low part of previous * weight
	localparam logic [3:0] ST_FIN  = 4'd8; // add the scaled low product
	localparam logic [3:0] ST_OUT  = 4'd9; // truncate, clamp, present

	// Configuration registers.
	logic [spdpi_pkg::GAIN_W-1:0]  prop_gain_q;
	logic [spdpi_pkg::GAIN_W-1:0]  integ_gain_q;
	logic [spdpi_pkg::ALPHA_W-1:0] filter_alpha_q;
	logic [spdpi_pkg::LIMIT_W-1:0] output_limit_q;

	// Controller state carried from item to item.
	logic signed [ERR_W-1:0] prev_err_q;
	logic signed [DW-1:0]    held_q;
	logic signed [FW-1:0]    prev_filt_q;

	// Working registers for one item.
	logic [3:0]               state_q;
	logic signed [ERR_W-1:0]  err_q;
	logic signed [DERR_W-1:0] derr_q;
	logic signed [31:0]       sum_q;
	logic signed [PR_W-1:0]   prod_q;
	logic signed [ACC_W-1:0]  acc_q;

	// Output register.
	logic                 m_valid_q;
	logic signed [DW-1:0] drive_q;
	logic                 sat_q;

	// Input fields.
	logic signed [SW-1:0]    target_speed;
	logic signed [SW-1:0]    measured_speed;
	logic signed [ERR_W-1:0] err_new;

	assign target_speed   = s_axis_tdata[SW-1:0];
	assign measured_speed = s_axis_tdata[2*SW-1:SW];
	assign err_new        = ERR_W'(target_speed) - ERR_W'(measured_speed);

	// Alpha above one acts as one; the complementary weight follows.
	logic [spdpi_pkg::ALPHA_W-1:0] alpha_eff;
	logic [spdpi_pkg::ALPHA_W-1:0] weight;

	assign alpha_eff = (filter_alpha_q > spdpi_pkg::ONE_Q16) ? spdpi_pkg::ONE_Q16
	                                                         : filter_alpha_q;
	assign weight    = spdpi_pkg::ONE_Q16 - alpha_eff;

	// The previous filter value splits into a floor part (arithmetic shift)
	// and an unsigned 16-bit fraction.
	logic signed [FW-17:0] prev_hi;
	logic [15:0]           prev_lo;

	assign prev_hi = prev_filt_q[FW-1:16];
	assign prev_lo = prev_filt_q[15:0];

	// ------------------------------------------------------------------
	// Shared multiplier with its operand selection.
	// ------------------------------------------------------------------
	logic signed [MA_W-1:0] mul_a;
	logic signed [MB_W-1:0] mul_b;
	logic signed [PR_W-1:0] mul_p;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MP: begin
				mul_a = MA_W'(derr_q);
				mul_b = {2'b00, prop_gain_q};
			end
			ST_MI: begin
				mul_a = MA_W'(err_q);
				mul_b = {2'b00, integ_gain_q};
			end
			ST_MS: begin
				mul_a = MA_W'(sum_q);
				mul_b = {1'b0, alpha_eff};
			end
			ST_MH: begin
				mul_a = MA_W'(prev_hi);
				mul_b = {1'b0, weight};
			end
			ST_ML: begin
				mul_a = {{(MA_W-16){1'b0}}, prev_lo};
				mul_b = {1'b0, weight};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// ------------------------------------------------------------------
	// Increment: the PI numerator divided by 256, rounded toward zero,
	// then added to the held output and saturated to signed 32 bits.
	// ------------------------------------------------------------------
	logic signed [INC_W-1:0] inc;
	logic signed [SUM_W-1:0] sum_wide;
	logic signed [31:0]      sum_sat;

	assign inc = acc_q[ACC_W-1:8]
	           + INC_W'(acc_q[ACC_W-1] && (acc_q[7:0] != 8'd0));
	assign sum_wide = SUM_W'(held_q) + SUM_W'(inc);

	always_comb begin
		if (sum_wide > SAT_HI) begin
			sum_sat = 32'sh7FFF_FFFF;
		end else if (sum_wide < SAT_LO) begin
			sum_sat = 32'sh8000_0000;
		end else begin
			sum_sat = sum_wide[31:0];
		end
	end

	// ------------------------------------------------------------------
	// Output: the filter value divided by 65536 toward zero, then clamped
	// to the symmetric limit. A zero limit yields zero with the flag set.
	// ------------------------------------------------------------------
	logic signed [O_W-1:0] out_trunc;
	logic signed [O_W-1:0] lim_pos;
	logic signed [O_W-1:0] lim_neg;
	logic signed [O_W-1:0] out_clamp;
	logic                  out_sat;

	assign out_trunc = acc_q[ACC_W-1:16]
	                 + O_W'(acc_q[ACC_W-1] && (acc_q[15:0] != 16'd0));
	assign lim_pos   = O_W'(output_limit_q);
	assign lim_neg   = -lim_pos;

	always_comb begin
		if (out_trunc >= lim_pos) begin
			out_clamp = lim_pos;
			out_sat   = 1'b1;
		end else if (out_trunc <= lim_neg) begin
			out_clamp = lim_neg;
			out_sat   = 1'b1;
		end else begin
			out_clamp = out_trunc;
			out_sat   = 1'b0;
		end
	end

	logic out_load;
	assign out_load = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);

	// ------------------------------------------------------------------
	// Configuration registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q    <= spdpi_pkg::PROP_GAIN_RST;
			integ_gain_q   <= spdpi_pkg::INTEG_GAIN_RST;
			filter_alpha_q <= spdpi_pkg::FILTER_ALPHA_RST;
			output_limit_q <= spdpi_pkg::OUTPUT_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				spdpi_pkg::REG_PROP_GAIN:    prop_gain_q    <= cfg_data[spdpi_pkg::GAIN_W-1:0];
				spdpi_pkg::REG_INTEG_GAIN:   integ_gain_q   <= cfg_data[spdpi_pkg::GAIN_W-1:0];
				spdpi_pkg::REG_FILTER_ALPHA: filter_alpha_q <= cfg_data[spdpi_pkg::ALPHA_W-1:0];
				spdpi_pkg::REG_OUTPUT_LIMIT: output_limit_q <= cfg_data[spdpi_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Sequencer and controller state.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_err_q  <= '0;
			held_q      <= '0;
			prev_filt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						prev_err_q <= err_new;
						state_q    <= ST_MP;
					end
				end
				ST_MP:  state_q <= ST_MI;
				ST_MI:  state_q <= ST_NUM;
				ST_NUM: state_q <= ST_SUM;
				ST_SUM: state_q <= ST_MS;
				ST_MS:  state_q <= ST_MH;
				ST_MH:  state_q <= ST_ML;
				ST_ML:  state_q <= ST_FIN;
				ST_FIN: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_load) begin
						prev_filt_q <= acc_q[FW-1:0];
						held_q      <= out_clamp[DW-1:0];
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers; the accumulator sums the products in turn.
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		case (state_q)
			ST_IDLE: begin
				err_q  <= err_new;
				derr_q <= DERR_W'(err_new) - DERR_W'(prev_err_q);
			end
			ST_MI:  acc_q <= ACC_W'(prod_q);
			ST_NUM: acc_q <= acc_q + ACC_W'(prod_q);
			ST_SUM: sum_q <= sum_sat;
			ST_MH:  acc_q <= ACC_W'(prod_q);
			ST_ML:  acc_q <= acc_q + ACC_W'(prod_q);
			ST_FIN: acc_q <= acc_q + ACC_W'(prod_q >>> 16);
			default: ;
		endcase
		if (out_load) begin
			drive_q <= out_clamp[DW-1:0];
			sat_q   <= out_sat;
		end
	end

	// Output valid flag; a waiting result does not block a new input.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = drive_q;
	assign m_axis_tuser  = sat_q;

endmodule
`default_nettype wire
